// ===== rtl/tjsc_pkg.sv =====
`timescale 1ns / 1ps

package tjsc_pkg;

  // Light phase codes shared by both roads
  typedef enum logic [1:0] {
    PH_RED       = 2'd0,
    PH_RED_AMBER = 2'd1,
    PH_GREEN     = 2'd2,
    PH_YELLOW    = 2'd3
  } phase_t;

  localparam int TIME_W     = 32;
  localparam int DUR_W      = 16;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = DUR_W;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_GREEN     = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_YELLOW    = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_RED_AMBER = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_RED       = 8'd3;

  // Reset durations in milliseconds
  localparam logic [DUR_W-1:0] GREEN_RST     = 16'd10000;
  localparam logic [DUR_W-1:0] YELLOW_RST    = 16'd5000;
  localparam logic [DUR_W-1:0] RED_AMBER_RST = 16'd1000;
  localparam logic [DUR_W-1:0] RED_RST       = 16'd10000;

  // Received byte that releases the held red
  localparam logic [7:0] RESUME_BYTE = 8'd200;

  typedef struct packed {
    logic [TIME_W-1:0] current_time;
    logic              button_pressed;
    logic              rx_valid;
    logic [7:0]        rx_byte;
  } in_item_t;

  typedef struct packed {
    phase_t main_phase;
    phase_t side_phase;
    logic   tx_permit;
  } out_item_t;

  typedef struct packed {
    logic [DUR_W-1:0] green;
    logic [DUR_W-1:0] yellow;
    logic [DUR_W-1:0] red_amber;
    logic [DUR_W-1:0] red;
  } cfg_t;

  typedef struct packed {
    phase_t            phase;
    logic [TIME_W-1:0] since;
    logic              walk;
    logic              permit;
  } main_st_t;

  typedef struct packed {
    phase_t            phase;
    logic [TIME_W-1:0] since;
  } side_st_t;

  // Wrapping elapsed-time test
  function automatic logic elapsed(input logic [TIME_W-1:0] now,
                                   input logic [TIME_W-1:0] since,
                                   input logic [DUR_W-1:0]  dur);
    logic [TIME_W-1:0] diff;
    diff = now - since;
    return diff >= {{(TIME_W-DUR_W){1'b0}}, dur};
  endfunction

endpackage

// ===== rtl/tjsc_if.sv =====
`timescale 1ns / 1ps

// Tick channel into the controller
interface tjsc_in_if;
  import tjsc_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// Light status channel out of the controller
interface tjsc_out_if;
  import tjsc_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/tjsc_main_step.sv =====
`timescale 1ns / 1ps

module tjsc_main_step (
  input  tjsc_pkg::in_item_t item,
  input  tjsc_pkg::cfg_t     cfg,
  input  tjsc_pkg::main_st_t cur,
  output tjsc_pkg::main_st_t nxt,
  output logic               tx_permit
);
  import tjsc_pkg::*;

  logic              resume;
  logic [TIME_W-1:0] now;

  assign now    = item.current_time;
  assign resume = item.rx_valid && (item.rx_byte == RESUME_BYTE);

  // Latch the button, apply the resume byte, then step the main light
  always_comb begin
    nxt       = cur;
    tx_permit = 1'b0;
    if (item.button_pressed) begin
      nxt.walk = 1'b1;
    end
    if (resume) begin
      nxt.walk  = 1'b0;
      nxt.phase = PH_RED_AMBER;
      nxt.since = now;
    end
    case (nxt.phase)
      PH_GREEN: begin
        if (elapsed(now, nxt.since, cfg.green)) begin
          nxt.phase = PH_YELLOW;
          nxt.since = now;
        end
      end
      PH_YELLOW: begin
        if (elapsed(now, nxt.since, cfg.yellow)) begin
          nxt.phase = PH_RED;
          nxt.since = now;
        end
      end
      PH_RED: begin
        // Pending request: send one permit and restart the red timer
        if (nxt.walk && !nxt.permit) begin
          tx_permit  = 1'b1;
          nxt.permit = 1'b1;
          nxt.since  = now;
        end
        if (!nxt.walk && elapsed(now, nxt.since, cfg.red)) begin
          nxt.phase = PH_RED_AMBER;
          nxt.since = now;
        end
      end
      default: begin
        nxt.permit = 1'b0;
        if (elapsed(now, nxt.since, cfg.red_amber)) begin
          nxt.phase = PH_GREEN;
          nxt.since = now;
        end
      end
    endcase
  end

endmodule

// ===== rtl/tjsc_side_step.sv =====
`timescale 1ns / 1ps

module tjsc_side_step (
  input  logic [tjsc_pkg::TIME_W-1:0] now,
  input  tjsc_pkg::phase_t            main_phase,
  input  tjsc_pkg::cfg_t              cfg,
  input  tjsc_pkg::side_st_t          cur,
  output tjsc_pkg::side_st_t          nxt
);
  import tjsc_pkg::*;

  // Force green under main red, otherwise run the side cycle
  always_comb begin
    nxt = cur;
    if (main_phase == PH_RED) begin
      if (cur.phase != PH_GREEN) begin
        nxt.phase = PH_GREEN;
        nxt.since = now;
      end
    end else begin
      // Leave green at once; yellow is evaluated in the same tick
      if (cur.phase == PH_GREEN) begin
        nxt.phase = PH_YELLOW;
        nxt.since = now;
      end
      case (nxt.phase)
        PH_RED: begin
          if (elapsed(now, nxt.since, cfg.red)) begin
            nxt.phase = PH_RED_AMBER;
            nxt.since = now;
          end
        end
        PH_YELLOW: begin
          if (elapsed(now, nxt.since, cfg.yellow)) begin
            nxt.phase = PH_RED;
            nxt.since = now;
          end
        end
        PH_RED_AMBER: begin
          if (elapsed(now, nxt.since, cfg.red_amber)) begin
            nxt.phase = PH_GREEN;
            nxt.since = now;
          end
        end
        default: begin
          nxt.phase = nxt.phase;
        end
      endcase
    end
  end

endmodule

// ===== rtl/t_junction_signal_controller_top.sv =====
`timescale 1ns / 1ps

// T-junction signal controller. Each request on in_ch is one update tick
// (millisecond time, pedestrian button, optional received byte) and yields
// exactly one result on out_ch with the main and side light phases after the
// tick and a flag for a crossing permit sent on that tick. A new tick is
// taken every clock cycle while out_ch does not stall; a result is offered
// on out_ch after its tick passes the input register and a single-pass light
// update into the result register. While a result waits on out_ch the input
// register still takes one more tick. Durations are to be written through
// cfg_we/cfg_idx/cfg_wdata by the user only while no tick is in flight, not
// enforced here; indexes beyond the last register are ignored.
module t_junction_signal_controller_top (
  input  logic                             clk,
  input  logic                             rst_n,
  tjsc_in_if.sink                          in_ch,
  tjsc_out_if.source                       out_ch,
  input  logic                             cfg_we,
  input  logic [tjsc_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [tjsc_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import tjsc_pkg::*;

  cfg_t      cfg_r;
  logic      in_v_r;
  in_item_t  in_d_r;
  logic      out_v_r;
  out_item_t out_d_r;
  main_st_t  main_r;
  main_st_t  main_nxt;
  side_st_t  side_r;
  side_st_t  side_nxt;
  logic      tx_nxt;
  logic      proc;

  // Step a tick when the result register is free or being drained
  assign proc         = in_v_r && (!out_v_r || out_ch.ready);
  assign in_ch.ready  = !in_v_r || proc;
  assign out_ch.valid = out_v_r;
  assign out_ch.data  = out_d_r;

  tjsc_main_step u_main (
    .item      (in_d_r),
    .cfg       (cfg_r),
    .cur       (main_r),
    .nxt       (main_nxt),
    .tx_permit (tx_nxt)
  );

  tjsc_side_step u_side (
    .now        (in_d_r.current_time),
    .main_phase (main_nxt.phase),
    .cfg        (cfg_r),
    .cur        (side_r),
    .nxt        (side_nxt)
  );

  // Hold duration registers; write on enable
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.green     <= GREEN_RST;
      cfg_r.yellow    <= YELLOW_RST;
      cfg_r.red_amber <= RED_AMBER_RST;
      cfg_r.red       <= RED_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_IDX_GREEN:     cfg_r.green     <= cfg_wdata;
        CFG_IDX_YELLOW:    cfg_r.yellow    <= cfg_wdata;
        CFG_IDX_RED_AMBER: cfg_r.red_amber <= cfg_wdata;
        CFG_IDX_RED:       cfg_r.red       <= cfg_wdata;
        default:           cfg_r           <= cfg_r;
      endcase
    end
  end

  // Input register: take a tick when free or stepping
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_d_r <= in_ch.data;
    end
  end

  // Light state and result register advance together
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r       <= 1'b0;
      main_r.phase  <= PH_RED;
      main_r.since  <= '0;
      main_r.walk   <= 1'b0;
      main_r.permit <= 1'b0;
      side_r.phase  <= PH_GREEN;
      side_r.since  <= '0;
    end else begin
      if (proc) begin
        out_v_r <= 1'b1;
        main_r  <= main_nxt;
        side_r  <= side_nxt;
      end else if (out_ch.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (proc) begin
      out_d_r.main_phase <= main_nxt.phase;
      out_d_r.side_phase <= side_nxt.phase;
      out_d_r.tx_permit  <= tx_nxt;
    end
  end

endmodule

// ===== rtl/tjsc_checker.sv =====
`timescale 1ns / 1ps

module tjsc_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input tjsc_pkg::phase_t   main_phase,
  input tjsc_pkg::phase_t   side_phase,
  input logic               tx_permit
);
  import tjsc_pkg::*;

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // Side road is green whenever main road is red
  a_side_green: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (main_phase == PH_RED) |-> (side_phase == PH_GREEN))
    else $error("side light not green under main red");

  // A permit is only sent while main road holds red
  a_permit_red: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && tx_permit |-> (main_phase == PH_RED))
    else $error("permit sent outside main red");

  // Ready to take a tick straight after reset
  a_ready_after_rst: assert property (@(posedge clk)
    $past(!rst_n) && rst_n |-> in_ready)
    else $error("input not ready after reset");

endmodule

bind t_junction_signal_controller_top tjsc_checker u_tjsc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .main_phase (out_ch.data.main_phase),
  .side_phase (out_ch.data.side_phase),
  .tx_permit  (out_ch.data.tx_permit)
);
